// File: design/bnn_pkg.sv
// Shared types and constants for the batch normalization block.
// No dependencies; every other design file but bnn_ram refers to this package by scope.
`timescale 1ns / 1ps
`default_nettype none
package bnn_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VAR_W      = 32;
    localparam int INV_W      = 32;
    localparam int EPS_W      = 16;
    localparam int CH_W       = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE  = 1'b1;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Parameter memory row: mean, inv_std, gain, offset
    localparam int PAR_W = SAMPLE_W + INV_W + SAMPLE_W + SAMPLE_W;

    typedef enum logic {
        OP_NORM = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] value;    // sample or mean
        logic [INV_W-1:0]           inv_std;
        logic signed [SAMPLE_W-1:0] gain;
        logic signed [SAMPLE_W-1:0] offset;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic busy;
        logic push;
    } front_stat_t;

endpackage
`default_nettype wire

// File: design/bnn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bnn_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: design/bnn_front.sv
// Front end: accepts beats, passes samples on, computes 1/sqrt(var+eps) for loads.
// Depends on bnn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bnn_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [bnn_pkg::EPS_W-1:0]     epsilon,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [bnn_pkg::CH_W-1:0]      s_channel,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0] s_mean_value,
    input  wire logic [bnn_pkg::VAR_W-1:0]     s_variance,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0] s_gain,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0] s_offset_value,
    input  wire bnn_pkg::queue_stat_t          q_stat,
    output logic                               push_valid,
    output bnn_pkg::cmd_t                      push_cmd,
    output bnn_pkg::front_stat_t               stat
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_PUSH
    } state_t;

    localparam int S_W   = 33;
    localparam int Q_W   = 51;   // quotient of 2^50 / S
    localparam int R_W   = 27;
    localparam logic [5:0] DIV_LAST_BIT = 6'd50;
    localparam logic [5:0] ROOT_TOP_BIT = 6'd26;

    state_t         state_reg;
    bnn_pkg::cmd_t  cmd_reg;
    logic [S_W-1:0] s_reg;
    logic [S_W-1:0] rem_reg;
    logic [Q_W-1:0] quo_reg;
    logic [R_W-1:0] root_reg;
    logic [5:0]     step_reg;

    logic [S_W-1:0]   s_in;
    logic [S_W:0]     rem_sh;
    logic [S_W+1:0]   trial;
    logic             trial_ge;
    logic [R_W-1:0]   cand;
    logic [2*R_W-1:0] cand_sq;
    logic [R_W-1:0]   root_new;
    logic [R_W:0]     root_inc;
    logic             accept;

    // One restoring divide step and one root bit trial
    always_comb begin
        s_in     = {1'b0, s_variance} + S_W'(epsilon);
        rem_sh   = {rem_reg, (step_reg == DIV_LAST_BIT)};
        trial    = {1'b0, rem_sh} - {2'b0, s_reg};
        trial_ge = !trial[S_W+1];
        cand     = root_reg | (R_W'(1) << step_reg[4:0]);
        cand_sq  = cand * cand;
        root_new = (cand_sq <= {3'b0, quo_reg}) ? cand : root_reg;
        root_inc = {1'b0, root_new} + (R_W+1)'(1);
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !q_stat.full;

    // Samples go straight to the queue; a finished load goes from the hold register
    always_comb begin
        push_valid = 1'b0;
        push_cmd   = cmd_reg;
        if (state_reg == ST_IDLE) begin
            push_valid       = accept && (s_func == bnn_pkg::OP_NORM);
            push_cmd.op      = bnn_pkg::OP_NORM;
            push_cmd.channel = s_channel;
            push_cmd.value   = s_sample;
        end else if (state_reg == ST_PUSH) begin
            push_valid = !q_stat.full;
        end
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.push = push_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_func == bnn_pkg::OP_LOAD)) begin
                        cmd_reg.op      <= bnn_pkg::OP_LOAD;
                        cmd_reg.channel <= s_channel;
                        cmd_reg.value   <= s_mean_value;
                        cmd_reg.gain    <= s_gain;
                        cmd_reg.offset  <= s_offset_value;
                        s_reg           <= s_in;
                        rem_reg         <= '0;
                        quo_reg         <= '0;
                        step_reg        <= DIV_LAST_BIT;
                        if (s_in == '0) begin
                            cmd_reg.inv_std <= '1;
                            state_reg       <= ST_PUSH;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg  <= trial_ge ? trial[S_W-1:0] : rem_sh[S_W-1:0];
                    quo_reg  <= {quo_reg[Q_W-2:0], trial_ge};
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == '0) begin
                        root_reg  <= '0;
                        step_reg  <= ROOT_TOP_BIT;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    root_reg <= root_new;
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == '0) begin
                        cmd_reg.inv_std <= bnn_pkg::INV_W'(root_inc[R_W:1]);
                        state_reg       <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!q_stat.full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/bnn_queue.sv
// Short command queue between front and back ends.
// Depends on bnn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bnn_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire bnn_pkg::cmd_t   push_cmd,
    input  wire logic            pop,
    output bnn_pkg::cmd_t        head,
    output bnn_pkg::queue_stat_t stat
);
    bnn_pkg::cmd_t                mem_reg [bnn_pkg::QDEPTH];
    logic [bnn_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [bnn_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [bnn_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign stat.full  = (count_reg == bnn_pkg::QCNT_W'(bnn_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: design/bnn_back.sv
// Back end: parameter memory, normalize pipeline, rounding and saturation.
// Depends on bnn_pkg and bnn_ram.
`timescale 1ns / 1ps
`default_nettype none
module bnn_back #(
    parameter int CHANNELS = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  affine_enable,
    input  wire logic                  q_valid,
    input  wire bnn_pkg::cmd_t         q_cmd,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [bnn_pkg::SAMPLE_W-1:0] m_result,
    output logic                       m_saturated
);
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = bnn_pkg::SAMPLE_W;
    localparam int DIFF_W = SW + 1;
    localparam int PROD_W = DIFF_W + bnn_pkg::INV_W + 1;
    localparam int ACC_W  = PROD_W + SW;
    localparam int FRAC   = 32;
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(64'sd32768 <<< FRAC);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

    logic                     en;
    logic [AW-1:0]            addr;
    logic [AW-1:0]            ch_map [2**bnn_pkg::CH_W];
    logic [bnn_pkg::PAR_W-1:0] wdata;
    logic [bnn_pkg::PAR_W-1:0] rdata;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic signed [SW-1:0]     sample1_reg;
    logic signed [DIFF_W-1:0] diff2_reg;
    logic [bnn_pkg::INV_W-1:0] inv2_reg;
    logic signed [SW-1:0]     gain2_reg, offset2_reg, gain3_reg, offset3_reg, offset4_reg;
    logic signed [PROD_W-1:0] prod3_reg, prod4_reg;
    logic signed [ACC_W-1:0]  mul4_reg;
    logic signed [SW-1:0]     result_reg;
    logic                     sat_reg;

    logic signed [SW-1:0]     mean1;
    logic signed [SW-1:0]     gain1, offset1;
    logic [bnn_pkg::INV_W-1:0] inv1;
    logic signed [DIFF_W-1:0] diff1;
    logic signed [PROD_W-1:0] prod2;
    logic signed [ACC_W-1:0]  mul3;
    logic signed [ACC_W-1:0]  acc4;
    logic signed [ACC_W-1:0]  w4;

    // Wrap each channel code into the table range
    for (genvar g = 0; g < 2**bnn_pkg::CH_W; g++) begin : g_ch_map
        assign ch_map[g] = AW'(g % CHANNELS);
    end

    // Whole pipeline advances when the output register is free or taken
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && q_valid;
    assign addr  = ch_map[q_cmd.channel];
    assign wdata = {q_cmd.value, q_cmd.inv_std, q_cmd.gain, q_cmd.offset};

    bnn_ram #(
        .WIDTH (bnn_pkg::PAR_W),
        .DEPTH (CHANNELS)
    ) u_par_ram (
        .aclk  (aclk),
        .we    (q_pop && (q_cmd.op == bnn_pkg::OP_LOAD)),
        .waddr (addr),
        .wdata (wdata),
        .re    (en),
        .raddr (addr),
        .rdata (rdata)
    );

    // Datapath arithmetic per stage
    always_comb begin
        {mean1, inv1, gain1, offset1} = rdata;
        diff1 = DIFF_W'(sample1_reg) - DIFF_W'(mean1);
        prod2 = PROD_W'(diff2_reg) * $signed({1'b0, inv2_reg});
        mul3  = ACC_W'(prod3_reg) * ACC_W'(gain3_reg);
        if (affine_enable) begin
            acc4 = mul4_reg + (ACC_W'(offset4_reg) <<< 24);
        end else begin
            acc4 = ACC_W'(prod4_reg) <<< 16;
        end
        w4 = acc4 + HALF;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= q_valid && (q_cmd.op == bnn_pkg::OP_NORM);
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            m_valid_reg <= v4_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            sample1_reg <= q_cmd.value;
            diff2_reg   <= diff1;
            inv2_reg    <= inv1;
            gain2_reg   <= gain1;
            offset2_reg <= offset1;
            prod3_reg   <= prod2;
            gain3_reg   <= gain2_reg;
            offset3_reg <= offset2_reg;
            mul4_reg    <= mul3;
            prod4_reg   <= prod3_reg;
            offset4_reg <= offset3_reg;
            if (v4_reg) begin
                if (w4 >= LIM_POS) begin
                    result_reg <= 16'sh7fff;
                    sat_reg    <= 1'b1;
                end else if (w4 < LIM_NEG) begin
                    result_reg <= 16'sh8000;
                    sat_reg    <= 1'b1;
                end else begin
                    result_reg <= w4[FRAC+SW-1:FRAC];
                    sat_reg    <= 1'b0;
                end
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_result    = result_reg;
    assign m_saturated = sat_reg;
endmodule
`default_nettype wire

// File: design/batchnorm_normalize.sv
// Inference batch normalization in fixed point.
// s_* channel: one beat is either a sample (s_func 0) or a channel parameter load (s_func 1).
// m_* channel: one beat per sample, a signed Q8.8 result with a saturation flag.
// cfg_*: write port for epsilon (index 0) and affine_enable (index 1); write only when idle.
// Samples are accepted one per cycle while s_ready is high (front end idle, queue not full).
// A load holds s_ready low while the front end's shared divide/root unit runs 51 restoring
// divide steps and 27 root bit trials, one a cycle.
// Loads produce no result beat.
// A four-entry command queue parts the front end from the back end pipeline, which holds
// everything in place while a result waits with m_ready low; the queue then fills and
// s_ready drops. The parameter memory is read whenever the pipeline advances; an entry
// read before it is loaded returns whatever it held.
// Reset (aresetn low, synchronous) empties the queue and pipeline and sets epsilon
// to 1 and affine_enable to 1; memory contents are not cleared.
// Depends on bnn_pkg, bnn_front, bnn_queue, bnn_back and bnn_ram.
`timescale 1ns / 1ps
`default_nettype none
module batchnorm_normalize #(
    parameter int CHANNELS = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [bnn_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [bnn_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_func,
    input  wire logic [bnn_pkg::CH_W-1:0]               s_channel,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0]    s_sample,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0]    s_mean_value,
    input  wire logic [bnn_pkg::VAR_W-1:0]              s_variance,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0]    s_gain,
    input  wire logic signed [bnn_pkg::SAMPLE_W-1:0]    s_offset_value,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [bnn_pkg::SAMPLE_W-1:0]         m_result,
    output logic                                        m_saturated
);
    logic [bnn_pkg::EPS_W-1:0] epsilon_reg;
    logic                      affine_reg;

    logic                  push_valid;
    bnn_pkg::cmd_t         push_cmd;
    bnn_pkg::cmd_t         q_head;
    bnn_pkg::queue_stat_t  q_stat;
    bnn_pkg::front_stat_t  f_stat;
    logic                  q_pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epsilon_reg <= bnn_pkg::EPS_W'(1);
            affine_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bnn_pkg::CFG_EPSILON: epsilon_reg <= cfg_wdata[bnn_pkg::EPS_W-1:0];
                bnn_pkg::CFG_AFFINE:  affine_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    bnn_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .epsilon        (epsilon_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_channel      (s_channel),
        .s_sample       (s_sample),
        .s_mean_value   (s_mean_value),
        .s_variance     (s_variance),
        .s_gain         (s_gain),
        .s_offset_value (s_offset_value),
        .q_stat         (q_stat),
        .push_valid     (push_valid),
        .push_cmd       (push_cmd),
        .stat           (f_stat)
    );

    bnn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    bnn_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .affine_enable (affine_reg),
        .q_valid       (!q_stat.empty),
        .q_cmd         (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_saturated   (m_saturated)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        f_stat.push |-> !q_stat.full)
        else $error("command pushed into full queue");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        f_stat.busy |-> !s_ready)
        else $error("input accepted while root unit busy");

    a_sat_extremes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_result == 16'sh7fff || m_result == 16'sh8000))
        else $error("saturated result not at range limit");

    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");
`endif
endmodule
`default_nettype wire
